// ----- hw/rtl/tcr_pkg.sv -----
// Shared types, constants and codes for the text console renderer.
// Used by tcr_ctrl, tcr_datapath and text_console_renderer.
`default_nettype none
package tcr_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int PADDR_W = 3;

  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] ATTR_RESET = 8'he1;
  localparam logic [7:0] CH_BS      = 8'd8;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NL      = 8'd10;
  localparam logic [7:0] CH_CR      = 8'd13;

  localparam logic [7:0] GC_CSRFORM   = 8'h4b;
  localparam logic [7:0] GC_FORM_P0   = 8'h8f;
  localparam logic [7:0] GC_FORM_P1   = 8'h20;
  localparam logic [7:0] GC_FORM_P2   = 8'h7b;
  localparam logic [7:0] GC_CSRW      = 8'h49;
  localparam logic [2:0] LAST_BYTE_IX = 3'd6;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_CELL  = 2'd1;
  localparam logic [1:0] KIND_SUPPR = 2'd2;

  localparam logic [0:0] REG_SUSPENDED = 1'b0;
  localparam logic [0:0] REG_ATTRIBUTE = 1'b1;

  localparam logic [1:0] CUR_HOLD = 2'd0;
  localparam logic [1:0] CUR_HOME = 2'd1;
  localparam logic [1:0] CUR_PUT  = 2'd2;

  localparam logic [2:0] MEM_NONE    = 3'd0;
  localparam logic [2:0] MEM_INIT    = 3'd1;
  localparam logic [2:0] MEM_FILL    = 3'd2;
  localparam logic [2:0] MEM_PUT     = 3'd3;
  localparam logic [2:0] MEM_MOVE_RD = 3'd4;
  localparam logic [2:0] MEM_MOVE_WR = 3'd5;
  localparam logic [2:0] MEM_READ    = 3'd6;

  localparam logic [1:0] CNT_HOLD      = 2'd0;
  localparam logic [1:0] CNT_ZERO      = 2'd1;
  localparam logic [1:0] CNT_INC       = 2'd2;
  localparam logic [1:0] CNT_BLANK_ROW = 2'd3;

  localparam logic [1:0] OUT_NONE = 2'd0;
  localparam logic [1:0] OUT_BYTE = 2'd1;
  localparam logic [1:0] OUT_CELL = 2'd2;

  typedef struct packed {
    logic       load;
    logic [1:0] cur_op;
    logic [2:0] mem_op;
    logic [1:0] cnt_op;
    logic [1:0] out_op;
  } tcr_cmd_t;

  typedef struct packed {
    logic need_scroll;
    logic last_cell;
    logic last_move;
    logic last_byte;
  } tcr_status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/tcr_ctrl.sv -----
// Controller state machine for the text console renderer.
// Depends on tcr_pkg; drives the command struct of tcr_datapath.
`default_nettype none
module tcr_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [1:0]          operation,
  input  wire logic                suspended,
  input  wire tcr_pkg::tcr_status_t status,
  output tcr_pkg::tcr_cmd_t        cmd,
  output logic                     busy
);
  import tcr_pkg::*;

  localparam logic [3:0] S_INIT    = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_PUT     = 4'd2;
  localparam logic [3:0] S_SCR_RD  = 4'd3;
  localparam logic [3:0] S_SCR_WR  = 4'd4;
  localparam logic [3:0] S_FILL    = 4'd5;
  localparam logic [3:0] S_EMIT    = 4'd6;
  localparam logic [3:0] S_RD_ADDR = 4'd7;
  localparam logic [3:0] S_RD_OUT  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_INIT: begin
        cmd.mem_op = MEM_INIT;
        if (status.last_cell) begin
          state_next = S_IDLE;
        end else begin
          cmd.cnt_op = CNT_INC;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (operation)
            OP_PUT: state_next = S_PUT;
            OP_CLEAR: begin
              cmd.cur_op = CUR_HOME;
              cmd.cnt_op = CNT_ZERO;
              state_next = suspended ? S_EMIT : S_FILL;
            end
            OP_READ: state_next = S_RD_ADDR;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_PUT: begin
        cmd.cur_op = CUR_PUT;
        cmd.mem_op = MEM_PUT;
        cmd.cnt_op = CNT_ZERO;
        state_next = status.need_scroll ? S_SCR_RD : S_EMIT;
      end
      S_SCR_RD: begin
        cmd.mem_op = MEM_MOVE_RD;
        state_next = S_SCR_WR;
      end
      S_SCR_WR: begin
        cmd.mem_op = MEM_MOVE_WR;
        if (status.last_move) begin
          cmd.cnt_op = CNT_BLANK_ROW;
          state_next = S_FILL;
        end else begin
          cmd.cnt_op = CNT_INC;
          state_next = S_SCR_RD;
        end
      end
      S_FILL: begin
        cmd.mem_op = MEM_FILL;
        if (status.last_cell) begin
          cmd.cnt_op = CNT_ZERO;
          state_next = S_EMIT;
        end else begin
          cmd.cnt_op = CNT_INC;
        end
      end
      S_EMIT: begin
        cmd.out_op = OUT_BYTE;
        cmd.cnt_op = CNT_INC;
        if (suspended || status.last_byte) begin
          state_next = S_IDLE;
        end
      end
      S_RD_ADDR: begin
        cmd.mem_op = MEM_READ;
        state_next = S_RD_OUT;
      end
      S_RD_OUT: begin
        cmd.out_op = OUT_CELL;
        state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/tcr_datapath.sv -----
// Datapath of the text console renderer: cursor, cell store, counter and
// result registers. Depends on tcr_pkg; commanded by tcr_ctrl.
`default_nettype none
module tcr_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tcr_pkg::tcr_cmd_t   cmd,
  output tcr_pkg::tcr_status_t     status,
  input  wire logic [7:0]          char_code,
  input  wire logic [10:0]         cell_index,
  input  wire logic                suspended,
  input  wire logic [7:0]          text_attribute,
  output logic                     result_valid,
  output logic [1:0]               kind,
  output logic                     to_command_port,
  output logic [7:0]               controller_byte,
  output logic [7:0]               cell_char,
  output logic [7:0]               cell_attr,
  output logic [4:0]               row_now,
  output logic [6:0]               column_now,
  output logic                     last
);
  import tcr_pkg::*;

  logic [15:0]       mem [CELLS];
  logic [15:0]       rdata;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [15:0]       wdata;

  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  row_next;
  logic [COL_W-1:0]  col_next;
  logic [ADDR_W-1:0] cnt;
  logic [7:0]        char_q;
  logic [10:0]       idx_q;
  logic              rd_ok;

  logic [ADDR_W-1:0] cur_addr;
  logic [15:0]       addr16;
  logic [COL_W:0]    col_ext;
  logic [COL_W:0]    col_inc;
  logic [COL_W:0]    col_tab;
  logic              newline;
  logic              printable;
  logic              at_bottom;
  logic              byte_cmd;
  logic [7:0]        byte_val;

  assign cur_addr = ADDR_W'(cur_row) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col);
  assign addr16   = 16'(cur_addr);
  assign col_ext  = {1'b0, cur_col};
  assign col_inc  = col_ext + (COL_W + 1)'(1);
  assign col_tab  = (col_ext + (COL_W + 1)'(8)) & ~((COL_W + 1)'(7));
  assign at_bottom = (32'(cur_row) >= ROWS - 1);
  assign printable = (char_q != CH_NL) && (char_q != CH_CR) && (char_q != CH_BS) &&
                     (char_q != CH_TAB);

  always_comb begin
    newline  = 1'b0;
    col_next = cur_col;
    case (char_q)
      CH_NL: newline = 1'b1;
      CH_CR: col_next = '0;
      CH_BS: begin
        if (cur_col != '0) begin
          col_next = cur_col - COL_W'(1);
        end
      end
      CH_TAB: begin
        if (32'(col_tab) >= COLUMNS) begin
          newline = 1'b1;
        end else begin
          col_next = col_tab[COL_W-1:0];
        end
      end
      default: begin
        if (32'(col_inc) >= COLUMNS) begin
          newline = 1'b1;
        end else begin
          col_next = col_inc[COL_W-1:0];
        end
      end
    endcase
    row_next = cur_row;
    if (newline) begin
      col_next = '0;
      if (at_bottom) begin
        row_next = ROW_W'(ROWS - 1);
      end else begin
        row_next = cur_row + ROW_W'(1);
      end
    end
  end

  assign status.need_scroll = newline && at_bottom && !suspended;
  assign status.last_cell   = (32'(cnt) == CELLS - 1);
  assign status.last_move   = (32'(cnt) == CELLS - COLUMNS - 1);
  assign status.last_byte   = (cnt[2:0] == LAST_BYTE_IX);

  always_comb begin
    we    = 1'b0;
    waddr = cnt;
    wdata = {text_attribute, BLANK_CHAR};
    raddr = ADDR_W'(cnt + ADDR_W'(COLUMNS));
    case (cmd.mem_op)
      MEM_INIT: begin
        we    = 1'b1;
        wdata = {ATTR_RESET, BLANK_CHAR};
      end
      MEM_FILL: we = 1'b1;
      MEM_PUT: begin
        we    = printable && !suspended;
        waddr = cur_addr;
        wdata = {text_attribute, char_q};
      end
      MEM_MOVE_WR: begin
        we    = 1'b1;
        wdata = rdata;
      end
      MEM_READ: raddr = ADDR_W'(idx_q);
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
    if (cmd.mem_op == MEM_READ) begin
      rd_ok <= (32'(idx_q) < CELLS);
    end
    if (cmd.load) begin
      char_q <= char_code;
      idx_q  <= cell_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row <= '0;
      cur_col <= '0;
      cnt     <= '0;
    end else begin
      case (cmd.cur_op)
        CUR_HOME: begin
          cur_row <= '0;
          cur_col <= '0;
        end
        CUR_PUT: begin
          cur_row <= row_next;
          cur_col <= col_next;
        end
        default: cur_row <= cur_row;
      endcase
      case (cmd.cnt_op)
        CNT_ZERO:      cnt <= '0;
        CNT_INC:       cnt <= cnt + ADDR_W'(1);
        CNT_BLANK_ROW: cnt <= ADDR_W'(CELLS - COLUMNS);
        default:       cnt <= cnt;
      endcase
    end
  end

  always_comb begin
    byte_cmd = 1'b0;
    case (cnt[2:0])
      3'd0: begin
        byte_cmd = 1'b1;
        byte_val = GC_CSRFORM;
      end
      3'd1: byte_val = GC_FORM_P0;
      3'd2: byte_val = GC_FORM_P1;
      3'd3: byte_val = GC_FORM_P2;
      3'd4: begin
        byte_cmd = 1'b1;
        byte_val = GC_CSRW;
      end
      3'd5: byte_val = addr16[7:0];
      default: byte_val = addr16[15:8];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (cmd.out_op == OUT_BYTE) || (cmd.out_op == OUT_CELL);
    end
  end

  always_ff @(posedge clk) begin
    row_now    <= 5'(cur_row);
    column_now <= 7'(cur_col);
    case (cmd.out_op)
      OUT_BYTE: begin
        cell_char <= '0;
        cell_attr <= '0;
        if (suspended) begin
          kind            <= KIND_SUPPR;
          to_command_port <= 1'b0;
          controller_byte <= '0;
          last            <= 1'b1;
        end else begin
          kind            <= KIND_BYTE;
          to_command_port <= byte_cmd;
          controller_byte <= byte_val;
          last            <= status.last_byte;
        end
      end
      OUT_CELL: begin
        kind            <= KIND_CELL;
        to_command_port <= 1'b0;
        controller_byte <= '0;
        cell_char       <= rd_ok ? rdata[7:0] : 8'h00;
        cell_attr       <= rd_ok ? rdata[15:8] : 8'h00;
        last            <= 1'b1;
      end
      default: last <= last;
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/text_console_renderer.sv -----
// Top level of the text console renderer: configuration registers, the
// controller tcr_ctrl and the datapath tcr_datapath. Depends on tcr_pkg.
//
// Usage: an item is taken when start is high and busy is low. A put item
// writes the cell (if printable and not suspended), moves the cursor and
// then emits the seven controller bytes, one per cycle; a clear item blanks
// the store and homes the cursor before the same bytes; a read item returns
// one cell. When suspended, a put or clear emits a single suppressed marker
// instead of the bytes, and a clear homes the cursor without blanking.
// Each result is shown for one cycle with result_valid high; last marks the
// final result of an item. The receiver cannot stall the block. A scroll
// moves the rows up and then blanks the bottom row, and a clear blanks every
// cell; each is paced by the single write port of the cell store. busy drops
// in the cycle that shows the last result, so the next item can be taken at
// the edge that ends it. After reset busy stays high while the store is
// swept to blanks; configuration writes are taken meanwhile.
`default_nettype none
module text_console_renderer (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 operation,
  input  wire logic [7:0]                 char_code,
  input  wire logic [10:0]                cell_index,
  output logic                            result_valid,
  output logic [1:0]                      kind,
  output logic                            to_command_port,
  output logic [7:0]                      controller_byte,
  output logic [7:0]                      cell_char,
  output logic [7:0]                      cell_attr,
  output logic [4:0]                      row_now,
  output logic [6:0]                      column_now,
  output logic                            last,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tcr_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import tcr_pkg::*;

  logic        suspended;
  logic [7:0]  text_attribute;
  logic        cfg_write;
  tcr_cmd_t    cmd;
  tcr_status_t status;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      suspended      <= 1'b0;
      text_attribute <= ATTR_RESET;
    end else if (cfg_write) begin
      case (paddr[2:2])
        REG_SUSPENDED: suspended <= pwdata[0];
        REG_ATTRIBUTE: text_attribute <= pwdata[7:0];
        default:       suspended <= suspended;
      endcase
    end
  end

  always_comb begin
    case (paddr[2:2])
      REG_SUSPENDED: prdata = {31'b0, suspended};
      REG_ATTRIBUTE: prdata = {24'b0, text_attribute};
      default:       prdata = '0;
    endcase
  end

  tcr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .suspended (suspended),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  tcr_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .char_code       (char_code),
    .cell_index      (cell_index),
    .suspended       (suspended),
    .text_attribute  (text_attribute),
    .result_valid    (result_valid),
    .kind            (kind),
    .to_command_port (to_command_port),
    .controller_byte (controller_byte),
    .cell_char       (cell_char),
    .cell_attr       (cell_attr),
    .row_now         (row_now),
    .column_now      (column_now),
    .last            (last)
  );

endmodule
`default_nettype wire
